/* rtl/snf_pkg.sv */
// Shared constants, types and helpers for the FAT short-name formatter.
package snf_pkg;

    localparam int unsigned NAME_LEN  = 11;
    localparam int unsigned BASE_LEN  = 8;
    localparam int unsigned SLOT_W    = 4;
    localparam int unsigned CNT_W     = 4;

    localparam logic [7:0] NUL_CHAR   = 8'h00;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    localparam logic [SLOT_W-1:0] BASE_SLOT = SLOT_W'(BASE_LEN);
    localparam logic [SLOT_W-1:0] END_SLOT  = SLOT_W'(NAME_LEN);
    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(NAME_LEN - 1);

    typedef logic [NAME_LEN-1:0][7:0] name_t;

    // Finished name handed from the builder to the output stage
    typedef struct packed {
        logic  valid;
        logic  ok;
        name_t bytes;
    } snf_load_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[LOWER_A:LOWER_Z]}) begin
            r = c - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

/* rtl/snf_input.sv */
// Input register stage: holds one character until the builder takes it.
module snf_input
    import snf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    output logic       in_valid,
    output logic [7:0] in_char,
    input  logic       in_take
);

    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       load;

    assign s_axis_tready = !valid_reg || in_take;
    assign load          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        char_next  = char_reg;
        if (load) begin
            valid_next = 1'b1;
            char_next  = s_axis_tdata;
        end else if (in_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        char_reg <= char_next;
    end

    assign in_valid = valid_reg;
    assign in_char  = char_reg;

endmodule

/* rtl/snf_builder.sv */
// Name builder: upper-cases characters into the 11-byte buffer and tracks rejection.
module snf_builder
    import snf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic [7:0] in_char,
    output logic      in_take,
    input  logic      emit_free,
    output snf_load_t load
);

    name_t             buf_reg, buf_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              ext_reg, ext_next;
    logic              rej_reg, rej_next;
    logic              is_nul;

    assign is_nul  = (in_char == NUL_CHAR);
    // a terminator waits until the output stage can take the whole name
    assign in_take = in_valid && (!is_nul || emit_free);

    assign load.valid = in_take && is_nul;
    assign load.ok    = !rej_reg;
    assign load.bytes = buf_reg;

    always_comb begin
        buf_next  = buf_reg;
        slot_next = slot_reg;
        ext_next  = ext_reg;
        rej_next  = rej_reg;
        if (in_take) begin
            if (is_nul) begin
                buf_next  = {NAME_LEN{SPACE_CHAR}};
                slot_next = '0;
                ext_next  = 1'b0;
                rej_next  = 1'b0;
            end else if (!rej_reg) begin
                if (in_char == DOT_CHAR) begin
                    if (ext_reg) begin
                        rej_next = 1'b1;
                    end else begin
                        ext_next  = 1'b1;
                        slot_next = BASE_SLOT;
                    end
                end else if (slot_reg >= END_SLOT || (slot_reg >= BASE_SLOT && !ext_reg)) begin
                    rej_next = 1'b1;
                end else begin
                    for (int i = 0; i < NAME_LEN; i++) begin
                        if (slot_reg == SLOT_W'(i)) begin
                            buf_next[i] = upcase(in_char);
                        end
                    end
                    slot_next = slot_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= {NAME_LEN{SPACE_CHAR}};
            slot_reg <= '0;
            ext_reg  <= 1'b0;
            rej_reg  <= 1'b0;
        end else begin
            buf_reg  <= buf_next;
            slot_reg <= slot_next;
            ext_reg  <= ext_next;
            rej_reg  <= rej_next;
        end
    end

`ifndef ASSERT_OFF
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= END_SLOT)
        else $error("write slot past end of name");

    a_rej_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        rej_reg && !load.valid |=> rej_reg)
        else $error("rejection cleared before terminator");

    a_base_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        !ext_reg |-> slot_reg <= BASE_SLOT)
        else $error("base name overran slot 8");
`endif

endmodule

/* rtl/snf_emitter.sv */
// Output stage: shifts a finished name out one byte per beat.
module snf_emitter
    import snf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  snf_load_t  load,
    output logic       emit_free,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic       m_axis_tuser,
    output logic       m_axis_tlast
);

    name_t            buf_reg, buf_next;
    logic             ok_reg, ok_next;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             beat, last;

    assign last      = (cnt_reg == LAST_CNT);
    assign beat      = busy_reg && m_axis_tready;
    assign emit_free = !busy_reg || (beat && last);

    always_comb begin
        buf_next  = buf_reg;
        ok_next   = ok_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load.valid) begin
            buf_next  = load.bytes;
            ok_next   = load.ok;
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (beat) begin
            buf_next = {SPACE_CHAR, buf_reg[NAME_LEN-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        buf_reg <= buf_next;
        ok_reg  <= ok_next;
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = buf_reg[0];
    assign m_axis_tuser  = ok_reg;
    assign m_axis_tlast  = last;

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load.valid |-> emit_free)
        else $error("name loaded while previous burst still draining");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg <= LAST_CNT)
        else $error("byte counter past last slot");

    a_burst_end: assert property (@(posedge aclk) disable iff (!aresetn)
        beat && last && !load.valid |=> !busy_reg)
        else $error("output stayed busy after last byte");

    a_ok_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !load.valid |=> $stable(ok_reg))
        else $error("status flag changed inside a burst");
`endif

endmodule

/* rtl/short_name_formatter_top.sv */
// A character is registered on accept and applied to the name buffer when the builder takes it.
// A terminating zero is loaded into the output stage once it is free, starting its 11-byte burst; bytes leave
// at one per cycle when m_axis_tready is high. Throughput: one character per cycle;
// a terminator stalls only while the previous burst is still draining.
// Reset (aresetn low, synchronous): buffer to spaces, slot/flags cleared, no output.
module short_name_formatter_top
    import snf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] name_byte
    output logic       m_axis_tuser,   // [0] name_ok
    output logic       m_axis_tlast
);

    logic       in_valid;
    logic [7:0] in_char;
    logic       in_take;
    logic       emit_free;
    snf_load_t  load;

    snf_input u_input (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .in_valid      (in_valid),
        .in_char       (in_char),
        .in_take       (in_take)
    );

    snf_builder u_builder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_char   (in_char),
        .in_take   (in_take),
        .emit_free (emit_free),
        .load      (load)
    );

    snf_emitter u_emitter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .emit_free     (emit_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
